### rtl/core/gdt_pkg.sv
// gdt_pkg: shared constants, sequencer states and the exp2 fraction table
// for the 1d gaussian / difference-of-gaussians tap generator
// no dependencies
package gdt_pkg;

  localparam int TAP_W         = 6;
  localparam int MAX_TAPS_DEF  = 63;
  localparam int TAP_COUNT_RST = 5;
  localparam int PADDR_W       = 3;

  localparam logic REG_TAP_COUNT = 1'b0;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_COUNT = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ERR,
    ST_SQ, ST_I2, ST_CHK, ST_DIV, ST_MUL, ST_EXP, ST_FIN, ST_FWR,
    ST_NRD, ST_NA, ST_NB, ST_ND, ST_NM, ST_NT, ST_NWR,
    ST_ORD, ST_OD, ST_OD2, ST_OD3, ST_OQ, ST_OEMIT
  } state_t;

  // round(65536 * 2^(-j/16)), j = 0..16
  function automatic logic [16:0] exp2_frac(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/gaussian_dog_taps_1d_unit.sv
// gaussian_dog_taps_1d_unit: top level of the 1d gaussian / dog tap generator
// depends on gdt_pkg; holds both tap memories and the shared serial divider
//
// usage
// - config: apb-style write of tap_count at byte address 0 (odd, 3..MAX_TAPS),
//   only while the block is idle; pready is tied high, reads return tap_count
// - input channel (in_valid/in_ready): one beat is one request carrying
//   operation, sigma_a, sigma_b and sensitivity
// - output channel (out_valid/out_ready): tap_count beats, tap_index 0 first,
//   last set on the final beat; a bad tap_count gives a single beat with
//   status set, coefficient 0 and last set
// - sequence: per tap the fill runs a 22-step divide for the exponent
//   argument plus multiplier stages, both skipped when the argument is out
//   of range; a dog request fills both sigmas, and its normalize and output
//   passes add divides per tap; receiver stalls lengthen any request
// - throughput: one request at a time; the serial divider and the single
//   port of each tap memory set the figure
// - a new request is taken once the final beat sits in the output register
// - reset clears the sequencer, the output valid, the sums and sets
//   tap_count to 5; tap memory contents stay unknown until filled
// - a stalled receiver holds the sequencer in its emit state, nothing lost
module gaussian_dog_taps_1d_unit #(
  parameter int MAX_TAPS = gdt_pkg::MAX_TAPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gdt_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // request channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       operation,
  input  logic [15:0]                sigma_a,
  input  logic [15:0]                sigma_b,
  input  logic signed [15:0]         sensitivity,
  // tap channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [15:0]         coefficient,
  output logic [gdt_pkg::TAP_W-1:0]  tap_index,
  output logic                       status,
  output logic                       last
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TW = gdt_pkg::TAP_W;

  gdt_pkg::state_t state, state_next;

  // config register
  logic [TW-1:0] tap_count;

  // request latch
  logic               dog;
  logic [15:0]        sa, sb;
  logic signed [15:0] sens;
  logic [TW-1:0]      n;
  logic               sel_b;
  logic [TW-1:0]      k;

  // tap memories
  logic [15:0] mem_a [MAX_TAPS];
  logic [15:0] mem_b [MAX_TAPS];
  logic [15:0] rd_a, rd_b;
  logic        we_a, we_b;
  logic [15:0] wd_a, wd_b;
  logic [AW-1:0] addr;

  // fill datapath
  logic [31:0] s2;
  logic [11:0] i2;
  logic [38:0] yprod;
  logic [3:0]  en, ek;
  logic [23:0] diffp;
  logic [15:0] v;
  logic [23:0] sum_a, sum_b;

  // normalize / dog datapath
  logic [15:0]        ga_n, gb_n;
  logic signed [32:0] prod;
  logic signed [41:0] total;
  logic signed [41:0] dn;
  logic               neg;
  logic signed [15:0] coef;  // next beat's tap, held until the output frees

  // serial divider
  logic [31:0]     drem, dden;
  logic [21:0]     dqd;
  logic [4:0]      dcnt;
  gdt_pkg::state_t dret;

  // combinational helpers
  logic               bad_count;
  logic               out_free;
  logic               k_last;
  logic [TW-1:0]      half, tap_off;
  logic [15:0]        sig;
  logic [15:0]        sig_nz;
  logic [32:0]        dtry;
  logic               dge;
  logic [20:0]        xnum0;
  logic [16:0]        t_hi;
  logic [11:0]        tdiff;
  logic [16:0]        mval;
  logic [17:0]        mrnd;
  logic [30:0]        nnum;
  logic [15:0]        nsrc;
  logic signed [32:0] dval;
  logic signed [42:0] onum;
  logic [42:0]        omag;
  logic [42:0]        orsum;
  logic [30:0]        oa;

  assign pready   = 1'b1;
  assign in_ready = (state == gdt_pkg::ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign addr     = AW'(k);
  assign k_last   = (k == n - TW'(1));

  always_comb begin
    prdata = '0;
    if (paddr[2] == gdt_pkg::REG_TAP_COUNT) begin
      prdata = 32'(tap_count);
    end
  end

  always_comb begin
    bad_count = (tap_count < TW'(3)) || !tap_count[0] || (32'(tap_count) > MAX_TAPS);
    half    = n >> 1;
    tap_off = (k >= half) ? (k - half) : (half - k);
    sig     = sel_b ? sb : sa;
    sig_nz  = (sig == 16'd0) ? 16'd1 : sig;
    xnum0   = {i2, 9'b0};
    dtry    = {drem, dqd[21]};
    dge     = (dtry >= {1'b0, dden});
    t_hi    = gdt_pkg::exp2_frac({1'b0, ek});
    tdiff   = 12'(gdt_pkg::exp2_frac({1'b0, yprod[31:28]})
                 - gdt_pkg::exp2_frac(5'({1'b0, yprod[31:28]}) + 5'd1));
    mval    = t_hi - 17'((diffp + 24'd2048) >> 12);
    mrnd    = 18'(({1'b0, mval} + (18'd1 << en)) >> ({1'b0, en} + 5'd1));
    nsrc    = (state == gdt_pkg::ST_NB) ? rd_b : rd_a;
    nnum    = {nsrc, 15'b0} + 31'((state == gdt_pkg::ST_NB) ? sum_b[23:1] : sum_a[23:1]);
    dval    = $signed({5'b0, (state == gdt_pkg::ST_NT) ? ga_n : rd_a, 12'b0}) - prod;
    onum    = {dn[41], dn} - {total[41], total};
    omag    = onum[42] ? 43'(-onum) : 43'(onum);
    orsum   = omag + 43'({n, 11'b0});
    oa      = orsum[42:12];
  end

  // memories, synchronous read
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[addr] <= wd_a;
    end
    if (we_b) begin
      mem_b[addr] <= wd_b;
    end
    rd_a <= mem_a[addr];
    rd_b <= mem_b[addr];
  end

  always_comb begin
    we_a = 1'b0;
    we_b = 1'b0;
    wd_a = v;
    wd_b = v;
    if (state == gdt_pkg::ST_FWR) begin
      we_a = !sel_b;
      we_b = sel_b;
    end else if (state == gdt_pkg::ST_NWR) begin
      we_a = 1'b1;
      we_b = dog;
      wd_a = ga_n;
      wd_b = gb_n;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gdt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = bad_count ? gdt_pkg::ST_ERR : gdt_pkg::ST_SQ;
        end
      end
      gdt_pkg::ST_ERR:   if (out_free) state_next = gdt_pkg::ST_IDLE;
      gdt_pkg::ST_SQ:    state_next = gdt_pkg::ST_I2;
      gdt_pkg::ST_I2:    state_next = gdt_pkg::ST_CHK;
      gdt_pkg::ST_CHK: begin
        state_next = ({11'b0, xnum0} >= s2) ? gdt_pkg::ST_FWR : gdt_pkg::ST_DIV;
      end
      gdt_pkg::ST_DIV:   if (dcnt == 5'd1) state_next = dret;
      gdt_pkg::ST_MUL:   state_next = gdt_pkg::ST_EXP;
      gdt_pkg::ST_EXP: begin
        state_next = (yprod[38:36] != 3'd0) ? gdt_pkg::ST_FWR : gdt_pkg::ST_FIN;
      end
      gdt_pkg::ST_FIN:   state_next = gdt_pkg::ST_FWR;
      gdt_pkg::ST_FWR: begin
        if (!k_last) begin
          state_next = gdt_pkg::ST_I2;
        end else if (dog && !sel_b) begin
          state_next = gdt_pkg::ST_SQ;
        end else begin
          state_next = gdt_pkg::ST_NRD;
        end
      end
      gdt_pkg::ST_NRD:   state_next = gdt_pkg::ST_NA;
      gdt_pkg::ST_NA:    state_next = gdt_pkg::ST_DIV;
      gdt_pkg::ST_NB:    state_next = dog ? gdt_pkg::ST_DIV : gdt_pkg::ST_NWR;
      gdt_pkg::ST_ND:    state_next = gdt_pkg::ST_NM;
      gdt_pkg::ST_NM:    state_next = gdt_pkg::ST_NT;
      gdt_pkg::ST_NT:    state_next = gdt_pkg::ST_NWR;
      gdt_pkg::ST_NWR:   state_next = k_last ? gdt_pkg::ST_ORD : gdt_pkg::ST_NRD;
      gdt_pkg::ST_ORD:   state_next = gdt_pkg::ST_OD;
      gdt_pkg::ST_OD:    state_next = dog ? gdt_pkg::ST_OD2 : gdt_pkg::ST_OEMIT;
      gdt_pkg::ST_OD2:   state_next = gdt_pkg::ST_OD3;
      gdt_pkg::ST_OD3: begin
        state_next = (oa[30:16] >= 15'(n)) ? gdt_pkg::ST_OEMIT : gdt_pkg::ST_DIV;
      end
      gdt_pkg::ST_OQ:    state_next = gdt_pkg::ST_OEMIT;
      gdt_pkg::ST_OEMIT: begin
        if (out_free) begin
          state_next = k_last ? gdt_pkg::ST_IDLE : gdt_pkg::ST_ORD;
        end
      end
      default:           state_next = gdt_pkg::ST_IDLE;
    endcase
  end

  // config and control registers with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TW'(gdt_pkg::TAP_COUNT_RST);
      out_valid <= 1'b0;
      sum_a     <= '0;
      sum_b     <= '0;
    end else begin
      if (psel && penable && pwrite && (paddr[2] == gdt_pkg::REG_TAP_COUNT)) begin
        tap_count <= pwdata[TW-1:0];
      end
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if ((state == gdt_pkg::ST_ERR || state == gdt_pkg::ST_OEMIT) && out_free) begin
        out_valid <= 1'b1;
      end
      if (state == gdt_pkg::ST_SQ) begin
        if (sel_b) sum_b <= '0;
        else       sum_a <= '0;
      end
      if (state == gdt_pkg::ST_FWR) begin
        if (sel_b) sum_b <= sum_b + 24'(v);
        else       sum_a <= sum_a + 24'(v);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      gdt_pkg::ST_IDLE: begin
        dog   <= operation;
        sa    <= sigma_a;
        sb    <= sigma_b;
        sens  <= sensitivity;
        n     <= tap_count;
        sel_b <= 1'b0;
        total <= '0;
      end
      gdt_pkg::ST_ERR: begin
        if (out_free) begin
          coefficient <= '0;
          tap_index   <= '0;
          status      <= gdt_pkg::STATUS_BAD_COUNT;
          last        <= 1'b1;
        end
      end
      gdt_pkg::ST_SQ: begin
        s2 <= sig_nz * sig_nz;
        k  <= '0;
      end
      gdt_pkg::ST_I2: begin
        i2 <= 12'(tap_off) * 12'(tap_off);
      end
      gdt_pkg::ST_CHK: begin
        v    <= '0;
        drem <= 32'(xnum0);
        dden <= s2;
        dqd  <= '0;
        dcnt <= 5'd22;
        dret <= gdt_pkg::ST_MUL;
      end
      gdt_pkg::ST_DIV: begin
        drem <= dge ? 32'(dtry - {1'b0, dden}) : dtry[31:0];
        dqd  <= {dqd[20:0], dge};
        dcnt <= dcnt - 5'd1;
      end
      gdt_pkg::ST_MUL: begin
        yprod <= 39'(dqd) * 39'd94548 + 39'd32768;
      end
      gdt_pkg::ST_EXP: begin
        v     <= '0;
        en    <= yprod[35:32];
        ek    <= yprod[31:28];
        diffp <= 24'(tdiff) * 24'(yprod[27:16]);
      end
      gdt_pkg::ST_FIN: begin
        v <= mrnd[15:0];
      end
      gdt_pkg::ST_FWR: begin
        if (k_last) begin
          k <= '0;
          if (dog && !sel_b) begin
            sel_b <= 1'b1;
          end
        end else begin
          k <= k + TW'(1);
        end
      end
      gdt_pkg::ST_NA: begin
        drem <= 32'(nnum[30:16]);
        dqd  <= {nnum[15:0], 6'b0};
        dden <= 32'(sum_a);
        dcnt <= 5'd16;
        dret <= gdt_pkg::ST_NB;
      end
      gdt_pkg::ST_NB: begin
        ga_n <= dqd[15:0];
        drem <= 32'(nnum[30:16]);
        dqd  <= {nnum[15:0], 6'b0};
        dden <= 32'(sum_b);
        dcnt <= 5'd16;
        dret <= gdt_pkg::ST_ND;
      end
      gdt_pkg::ST_ND: begin
        gb_n <= dqd[15:0];
      end
      gdt_pkg::ST_NM: begin
        prod <= sens * $signed({1'b0, gb_n});
      end
      gdt_pkg::ST_NT: begin
        total <= total + {{9{dval[32]}}, dval};
      end
      gdt_pkg::ST_NWR: begin
        k <= k_last ? '0 : k + TW'(1);
      end
      gdt_pkg::ST_OD: begin
        // gauss taps: clamp the center value 1.0 to the largest q1.15
        coef <= (rd_a > 16'd32767) ? 16'sd32767 : $signed(rd_a);
        prod <= sens * $signed({1'b0, rd_b});
      end
      gdt_pkg::ST_OD2: begin
        dn <= {{9{dval[32]}}, dval} * $signed({36'b0, n});
      end
      gdt_pkg::ST_OD3: begin
        neg <= onum[42];
        if (oa[30:16] >= 15'(n)) begin
          coef <= onum[42] ? -16'sd32768 : 16'sd32767;
        end
        drem <= 32'(oa[30:16]);
        dqd  <= {oa[15:0], 6'b0};
        dden <= 32'(n);
        dcnt <= 5'd16;
        dret <= gdt_pkg::ST_OQ;
      end
      gdt_pkg::ST_OQ: begin
        if (neg) begin
          coef <= (dqd[15:0] > 16'd32768) ? -16'sd32768 : $signed(16'(-dqd[15:0]));
        end else begin
          coef <= (dqd[15:0] > 16'd32767) ? 16'sd32767 : $signed(dqd[15:0]);
        end
      end
      gdt_pkg::ST_OEMIT: begin
        if (out_free) begin
          coefficient <= coef;
          tap_index   <= k;
          status      <= gdt_pkg::STATUS_OK;
          last        <= k_last;
          k           <= k + TW'(1);
        end
      end
      default: begin
        k <= k;
      end
    endcase
  end

endmodule
